[src/bc_texture_block_decoder_unit_defines.svh]
// ----------------------------------------------------------------------------
// bc texture block decoder assertion macros
// concurrent assertion helpers used by the checker file
// ----------------------------------------------------------------------------
`ifndef BC_TEXTURE_BLOCK_DECODER_UNIT_DEFINES_SVH
`define BC_TEXTURE_BLOCK_DECODER_UNIT_DEFINES_SVH

// same-cycle implication
`define BCTD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BCTD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/bctd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bctd_pkg
// shared types and constants of the bc texture block decoder
// ----------------------------------------------------------------------------
package bctd_pkg;

  localparam int unsigned TEXELS      = 16;
  localparam int unsigned TEXEL_W     = $clog2(TEXELS);
  localparam int unsigned CFG_DATA_W  = 12;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam logic [11:0] SWIZZLE_RESET = 12'd1672;

  typedef enum logic [1:0] {
    FMT_BC1 = 2'd0,
    FMT_BC2 = 2'd1,
    FMT_BC3 = 2'd2,
    FMT_BC5 = 2'd3
  } block_fmt_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BLOCK_FORMAT    = 1'b0,
    CFG_CHANNEL_SWIZZLE = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    DIV1 = 3'd0,
    DIV2 = 3'd1,
    DIV3 = 3'd2,
    DIV5 = 3'd3,
    DIV7 = 3'd4
  } div_e;

  typedef struct packed {
    logic [63:0] block_low;
    logic [63:0] block_high;
  } in_item_t;

  typedef struct packed {
    logic [3:0] texel_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       last_texel;
  } out_item_t;

  // classified block handed from front to back
  typedef struct packed {
    block_fmt_e       fmt;
    logic             four_mode;
    logic [2:0][7:0]  ep0;
    logic [2:0][7:0]  ep1;
    logic [31:0]      color_idx;
    logic [63:0]      alpha_lo;
    logic [63:0]      alpha_hi;
  } job_t;

  // one channel before its final division
  typedef struct packed {
    logic [10:0] num;
    div_e        div;
  } chan_t;

endpackage

[src/bctd_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bctd_queue
// small fifo of classified blocks between front and back
// ----------------------------------------------------------------------------
module bctd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  bctd_pkg::job_t item_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output bctd_pkg::job_t item_o
);
  import bctd_pkg::*;

  job_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              do_push, do_pop;

  assign full_o  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

[src/bctd_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bctd_front
// accepts a block, picks the colour word, expands endpoints, sets the mode
// ----------------------------------------------------------------------------
module bctd_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bctd_pkg::block_fmt_e format_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  bctd_pkg::in_item_t   in_item_i,
  output logic                 push_o,
  output bctd_pkg::job_t       job_o,
  input  logic                 full_i
);
  import bctd_pkg::*;

  logic        valid_q, valid_d;
  job_t        job_q, job_d;
  logic        accept;
  logic [63:0] cword;
  logic [15:0] c0, c1;

  // (v * 255 + 15) / 31 through reciprocal multiplication
  function automatic logic [7:0] expand5(input logic [4:0] v);
    logic [12:0] n;
    logic [26:0] p;
    n = 13'(v) * 13'd255 + 13'd15;
    p = 27'(n) * 27'd8457;
    return p[25:18];
  endfunction

  // (v * 255 + 31) / 63 through reciprocal multiplication
  function automatic logic [7:0] expand6(input logic [5:0] v);
    logic [13:0] n;
    logic [28:0] p;
    n = 14'(v) * 14'd255 + 14'd31;
    p = 29'(n) * 29'd16645;
    return p[27:20];
  endfunction

  assign in_stall_o = valid_q && full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = valid_q && !full_i;
  assign job_o      = job_q;

  always_comb begin
    cword = (format_i == FMT_BC1) ? in_item_i.block_low : in_item_i.block_high;
    c0    = cword[15:0];
    c1    = cword[31:16];
    job_d.fmt       = format_i;
    job_d.four_mode = (format_i != FMT_BC1) || (c0 > c1);
    job_d.ep0[0]    = expand5(c0[15:11]);
    job_d.ep0[1]    = expand6(c0[10:5]);
    job_d.ep0[2]    = expand5(c0[4:0]);
    job_d.ep1[0]    = expand5(c1[15:11]);
    job_d.ep1[1]    = expand6(c1[10:5]);
    job_d.ep1[2]    = expand5(c1[4:0]);
    job_d.color_idx = cword[63:32];
    job_d.alpha_lo  = in_item_i.block_low;
    job_d.alpha_hi  = in_item_i.block_high;
  end

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      job_q <= job_d;
    end
  end

endmodule

[src/bctd_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bctd_back
// walks the sixteen texels of a block: palette numerators, division, swizzle
// ----------------------------------------------------------------------------
module bctd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                job_valid_i,
  input  bctd_pkg::job_t      job_i,
  output logic                job_pop_o,
  input  logic [11:0]         swizzle_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output bctd_pkg::out_item_t out_item_o
);
  import bctd_pkg::*;

  logic [TEXEL_W-1:0] texel_q, texel_d;
  logic               s1_valid_q, s1_valid_d;
  logic [TEXEL_W-1:0] s1_texel_q;
  chan_t [3:0]        s1_chan_q, s1_chan_d;
  logic               out_valid_q, out_valid_d;
  out_item_t          out_item_q, out_item_d;
  logic               out_en, s1_en, issue;
  logic [1:0]         csel;
  logic [3:0][7:0]    px;
  logic [2:0]         sel;

  function automatic chan_t colour_chan(input logic [7:0] e0, input logic [7:0] e1,
                                        input logic [1:0] s, input logic four);
    chan_t r;
    r.num = 11'(e0);
    r.div = DIV1;
    case (s)
      2'd0: r.num = 11'(e0);
      2'd1: r.num = 11'(e1);
      2'd2: begin
        if (four) begin
          r.num = (11'(e0) << 1) + 11'(e1) + 11'd1;
          r.div = DIV3;
        end else begin
          r.num = 11'(e0) + 11'(e1);
          r.div = DIV2;
        end
      end
      default: begin
        if (four) begin
          r.num = 11'(e0) + (11'(e1) << 1) + 11'd1;
          r.div = DIV3;
        end else begin
          r.num = '0;
        end
      end
    endcase
    return r;
  endfunction

  function automatic chan_t alpha_chan(input logic [63:0] w, input logic [3:0] t);
    logic [7:0] a0, a1;
    logic [2:0] idx, w0, w1;
    chan_t      r;
    a0    = w[7:0];
    a1    = w[15:8];
    idx   = w[16 + 3 * t +: 3];
    w1    = idx - 3'd1;
    w0    = '0;
    r.div = DIV1;
    if (idx == 3'd0) begin
      r.num = 11'(a0);
    end else if (idx == 3'd1) begin
      r.num = 11'(a1);
    end else if (a0 > a1) begin
      w0    = 3'd0 - idx;
      r.num = 11'(w0) * 11'(a0) + 11'(w1) * 11'(a1) + 11'd3;
      r.div = DIV7;
    end else if (idx == 3'd6) begin
      r.num = '0;
    end else if (idx == 3'd7) begin
      r.num = 11'd255;
    end else begin
      w0    = 3'd6 - idx;
      r.num = 11'(w0) * 11'(a0) + 11'(w1) * 11'(a1) + 11'd2;
      r.div = DIV5;
    end
    return r;
  endfunction

  // division by small constants through reciprocal multiplication
  function automatic logic [7:0] div_apply(input chan_t c);
    logic [22:0] p;
    logic [7:0]  r;
    p = '0;
    unique case (c.div)
      DIV1: r = c.num[7:0];
      DIV2: r = c.num[8:1];
      DIV3: begin
        p = 23'(c.num) * 23'd683;
        r = p[18:11];
      end
      DIV5: begin
        p = 23'(c.num) * 23'd3277;
        r = p[21:14];
      end
      DIV7: begin
        p = 23'(c.num) * 23'd2341;
        r = p[21:14];
      end
      default: r = c.num[7:0];
    endcase
    return r;
  endfunction

  assign out_en      = !out_valid_q || !out_stall_i;
  assign s1_en       = !s1_valid_q || out_en;
  assign issue       = job_valid_i && s1_en;
  assign job_pop_o   = issue && (texel_q == TEXEL_W'(TEXELS - 1));
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;
  assign csel        = job_i.color_idx[2 * texel_q +: 2];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s1_chan_d[i] = colour_chan(job_i.ep0[i], job_i.ep1[i], csel, job_i.four_mode);
    end
    s1_chan_d[3].num = 11'd255;
    s1_chan_d[3].div = DIV1;
    unique case (job_i.fmt)
      FMT_BC1: begin
        if (csel == 2'd3 && !job_i.four_mode) begin
          s1_chan_d[3].num = '0;
        end
      end
      FMT_BC2: begin
        s1_chan_d[3].num = {3'b000, job_i.alpha_lo[4 * texel_q +: 4],
                            job_i.alpha_lo[4 * texel_q +: 4]};
      end
      FMT_BC3: s1_chan_d[3] = alpha_chan(job_i.alpha_lo, texel_q);
      FMT_BC5: begin
        s1_chan_d[0]     = alpha_chan(job_i.alpha_lo, texel_q);
        s1_chan_d[1]     = alpha_chan(job_i.alpha_hi, texel_q);
        s1_chan_d[2].num = '0;
        s1_chan_d[2].div = DIV1;
      end
      default: ;
    endcase
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      px[i] = div_apply(s1_chan_q[i]);
    end
    out_item_d.texel_index = s1_texel_q;
    out_item_d.last_texel  = (s1_texel_q == TEXEL_W'(TEXELS - 1));
    out_item_d.red         = '0;
    out_item_d.green       = '0;
    out_item_d.blue        = '0;
    out_item_d.alpha       = '0;
    for (int c = 0; c < 4; c++) begin
      sel = swizzle_i[3 * c +: 3];
      case (c)
        0: out_item_d.red   = sel[2] ? {8{sel[0]}} : px[sel[1:0]];
        1: out_item_d.green = sel[2] ? {8{sel[0]}} : px[sel[1:0]];
        2: out_item_d.blue  = sel[2] ? {8{sel[0]}} : px[sel[1:0]];
        default: out_item_d.alpha = sel[2] ? {8{sel[0]}} : px[sel[1:0]];
      endcase
    end
  end

  always_comb begin
    texel_d     = issue ? texel_q + 1'b1 : texel_q;
    s1_valid_d  = s1_en ? issue : s1_valid_q;
    out_valid_d = out_en ? s1_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      texel_q     <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      texel_q     <= texel_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_texel_q <= texel_q;
      s1_chan_q  <= s1_chan_d;
    end
    if (out_en && s1_valid_q) begin
      out_item_q <= out_item_d;
    end
  end

endmodule

[src/bc_texture_block_decoder_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bc_texture_block_decoder_unit
// bc1/bc2/bc3/bc5 4x4 block decoder with rgba8 texel output and swizzle
// ----------------------------------------------------------------------------
// Each accepted 128-bit block yields sixteen texels in row-major order, the
// sixteenth marked last. The texel walker in the back end emits one texel per
// cycle unless the output is stalled; the front end and a two-block queue
// take in further blocks while earlier ones are still being emitted. A block
// passes the front-end job register, the queue and the back end's stage-one
// and output registers to reach the port. Format and swizzle registers
// are to be written only while no block is in flight.
module bc_texture_block_decoder_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [bctd_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [bctd_pkg::CFG_DATA_W-1:0]       cfg_wdata_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  bctd_pkg::in_item_t                    in_item_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output bctd_pkg::out_item_t                   out_item_o
);
  import bctd_pkg::*;

  block_fmt_e  format_q, format_d;
  logic [11:0] swizzle_q, swizzle_d;
  logic        push, full, job_valid, job_pop;
  job_t        front_job, head_job;

  always_comb begin
    format_d  = format_q;
    swizzle_d = swizzle_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_BLOCK_FORMAT:    format_d  = block_fmt_e'(cfg_wdata_i[1:0]);
        CFG_CHANNEL_SWIZZLE: swizzle_d = cfg_wdata_i[11:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      format_q  <= FMT_BC1;
      swizzle_q <= SWIZZLE_RESET;
    end else begin
      format_q  <= format_d;
      swizzle_q <= swizzle_d;
    end
  end

  bctd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .format_i   (format_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .push_o     (push),
    .job_o      (front_job),
    .full_i     (full)
  );

  bctd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_job),
    .full_o  (full),
    .pop_i   (job_pop),
    .valid_o (job_valid),
    .item_o  (head_job)
  );

  bctd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (head_job),
    .job_pop_o   (job_pop),
    .swizzle_i   (swizzle_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

[src/bctd_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bctd_checker
// port-level checks of the block and texel streams, bound to the top level
// ----------------------------------------------------------------------------
`include "bc_texture_block_decoder_unit_defines.svh"

module bctd_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_stall_o,
  input bctd_pkg::in_item_t              in_item_i,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input bctd_pkg::out_item_t             out_item_o
);
  import bctd_pkg::*;

  `BCTD_ASSERT_NEXT(a_in_hold, in_valid_i && in_stall_o, in_valid_i && $stable(in_item_i), "stalled input transaction changed")
  `BCTD_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_item_o), "stalled transaction changed")
  `BCTD_ASSERT_NOW(a_last_mark, out_valid_o, out_item_o.last_texel == (out_item_o.texel_index == 4'hF), "last mark mismatch")
  `BCTD_ASSERT_NEXT(a_texel_run, out_valid_o && !out_stall_i && !out_item_o.last_texel, out_valid_o && (out_item_o.texel_index == $past(out_item_o.texel_index) + 4'd1), "texel run broken")

endmodule

bind bc_texture_block_decoder_unit bctd_checker u_checker (.*);

[sim/tb_bc_texture_block_decoder_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bc_texture_block_decoder_unit
// self-checking bench for the bc1/bc2/bc3/bc5 block decoder
// ----------------------------------------------------------------------------
// A driver streams 128-bit blocks from a queue and a monitor compares every
// texel with a behavioral decoder kept in the bench. The run walks through
// all four formats and several swizzle settings, starting with hand-picked
// endpoint and index patterns, then random blocks, under random sender gaps,
// random receiver stalls and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_bc_texture_block_decoder_unit;
  import bctd_pkg::*;

  localparam logic [2:0] SEL_R        = 3'd0;
  localparam logic [2:0] SEL_G        = 3'd1;
  localparam logic [2:0] SEL_B        = 3'd2;
  localparam logic [2:0] SEL_A        = 3'd3;
  localparam logic [2:0] SEL_ZERO     = 3'd4;
  localparam logic [2:0] SEL_FULL     = 3'd5;
  localparam logic [2:0] SEL_ZERO_ALT = 3'd6;
  localparam logic [2:0] SEL_FULL_ALT = 3'd7;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam logic [47:0] ALL_ALPHA_IDX = 48'hFAC688_FAC688;
  localparam logic [31:0] ALL_COLOR_IDX = 32'hE4E4_E4E4;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  in_item_t              in_item_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  out_item_t             out_item_o;

  in_item_t    pending_blocks[$];
  out_item_t   expected_texels[$];
  block_fmt_e  cur_fmt = FMT_BC1;
  logic [11:0] cur_swizzle = SWIZZLE_RESET;
  logic        in_taken = 1'b0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_req = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int          error_count = 0;
  int          texels_checked = 0;
  int          config_writes = 0;
  int          blocks_per_fmt[4] = '{0, 0, 0, 0};

  bc_texture_block_decoder_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("bc_texture_block_decoder_unit: mismatch");
    $finish;
  end

  // ---- behavioral decoder ----

  function automatic int unsigned expand_bits(int unsigned v, int unsigned top);
    return (v * 255 + top / 2) / top;
  endfunction

  function automatic logic [15:0][3:0][7:0] colour_texels(logic [63:0] w, bit four_only);
    logic [15:0]             c0;
    logic [15:0]             c1;
    int unsigned             e0[3];
    int unsigned             e1[3];
    bit                      four_mode;
    logic [3:0][3:0][7:0]    pal;
    logic [15:0][3:0][7:0]   px;
    c0 = w[15:0];
    c1 = w[31:16];
    four_mode = four_only || (c0 > c1);
    e0[0] = expand_bits(c0[15:11], 31);
    e0[1] = expand_bits(c0[10:5], 63);
    e0[2] = expand_bits(c0[4:0], 31);
    e1[0] = expand_bits(c1[15:11], 31);
    e1[1] = expand_bits(c1[10:5], 63);
    e1[2] = expand_bits(c1[4:0], 31);
    for (int c = 0; c < 3; c++) begin
      pal[0][c] = 8'(e0[c]);
      pal[1][c] = 8'(e1[c]);
      if (four_mode) begin
        pal[2][c] = 8'((2 * e0[c] + e1[c] + 1) / 3);
        pal[3][c] = 8'((e0[c] + 2 * e1[c] + 1) / 3);
      end else begin
        pal[2][c] = 8'((e0[c] + e1[c]) / 2);
        pal[3][c] = 8'd0;
      end
    end
    pal[0][3] = 8'd255;
    pal[1][3] = 8'd255;
    pal[2][3] = 8'd255;
    pal[3][3] = four_mode ? 8'd255 : 8'd0;
    for (int t = 0; t < 16; t++) px[t] = pal[w[32 + 2 * t +: 2]];
    return px;
  endfunction

  function automatic logic [15:0][7:0] interp_alpha(logic [63:0] w);
    int unsigned      a0;
    int unsigned      a1;
    logic [7:0][7:0]  tbl;
    logic [15:0][7:0] vals;
    a0 = w[7:0];
    a1 = w[15:8];
    tbl[0] = w[7:0];
    tbl[1] = w[15:8];
    if (a0 > a1) begin
      for (int unsigned i = 1; i < 7; i++) tbl[i + 1] = 8'(((7 - i) * a0 + i * a1 + 3) / 7);
    end else begin
      for (int unsigned i = 1; i < 5; i++) tbl[i + 1] = 8'(((5 - i) * a0 + i * a1 + 2) / 5);
      tbl[6] = 8'd0;
      tbl[7] = 8'd255;
    end
    for (int t = 0; t < 16; t++) vals[t] = tbl[w[16 + 3 * t +: 3]];
    return vals;
  endfunction

  function automatic logic [15:0][7:0] nibble_alpha(logic [63:0] w);
    logic [15:0][7:0] vals;
    for (int t = 0; t < 16; t++) vals[t] = 8'(w[4 * t +: 4] * 17);
    return vals;
  endfunction

  function automatic void predict_texels(in_item_t blk);
    logic [15:0][3:0][7:0] px;
    logic [15:0][7:0]      chan_a;
    logic [15:0][7:0]      chan_b;
    logic [3:0][7:0]       swz_px;
    logic [2:0]            sel;
    out_item_t             texel;
    case (cur_fmt)
      FMT_BC1: px = colour_texels(blk.block_low, 1'b0);
      FMT_BC2, FMT_BC3: begin
        px = colour_texels(blk.block_high, 1'b1);
        chan_a = (cur_fmt == FMT_BC2) ? nibble_alpha(blk.block_low) : interp_alpha(blk.block_low);
        for (int t = 0; t < 16; t++) px[t][3] = chan_a[t];
      end
      default: begin
        chan_a = interp_alpha(blk.block_low);
        chan_b = interp_alpha(blk.block_high);
        for (int t = 0; t < 16; t++) px[t] = {8'd255, 8'd0, chan_b[t], chan_a[t]};
      end
    endcase
    for (int t = 0; t < 16; t++) begin
      for (int c = 0; c < 4; c++) begin
        sel = cur_swizzle[3 * c +: 3];
        if (sel >= SEL_ZERO) sel = sel & SEL_FULL;
        case (sel)
          SEL_ZERO: swz_px[c] = 8'd0;
          SEL_FULL: swz_px[c] = 8'd255;
          default:  swz_px[c] = px[t][sel[1:0]];
        endcase
      end
      texel.texel_index = 4'(t);
      texel.red         = swz_px[0];
      texel.green       = swz_px[1];
      texel.blue        = swz_px[2];
      texel.alpha       = swz_px[3];
      texel.last_texel  = (t == 15);
      expected_texels.insert(expected_texels.size(), texel);
    end
  endfunction

  // ---- checking ----

  task automatic report_mismatch(string msg);
    if (error_count < 100) $display("ERROR @%0t ns: %s", $time, msg);
    error_count++;
  endtask

  task automatic compare_field(string name, int unsigned idx, int unsigned got,
                               int unsigned want);
    if (got != want)
      report_mismatch($sformatf("texel %0d %s got %0d want %0d", idx, name, got, want));
  endtask

  task automatic check_texel(out_item_t got);
    out_item_t want;
    if (expected_texels.size() == 0) begin
      report_mismatch($sformatf("texel %0d with no block pending", got.texel_index));
      return;
    end
    want = expected_texels.pop_front();
    texels_checked++;
    compare_field("index", want.texel_index, got.texel_index, want.texel_index);
    compare_field("red",   want.texel_index, got.red,         want.red);
    compare_field("green", want.texel_index, got.green,       want.green);
    compare_field("blue",  want.texel_index, got.blue,        want.blue);
    compare_field("alpha", want.texel_index, got.alpha,       want.alpha);
    compare_field("last",  want.texel_index, got.last_texel,  want.last_texel);
  endtask

  // ---- driver, receiver and monitor ----

  always @(negedge clk_i) begin
    if (rst_ni && !(in_valid_i && !in_taken)) begin
      if (pending_blocks.size() != 0 && $urandom_range(99) >= idle_pct) begin
        in_valid_i <= 1'b1;
        in_item_i  <= pending_blocks.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (hold_seen != hold_req) begin
      hold_seen   <= hold_req;
      hold_left   <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_taken <= in_valid_i && !in_stall_o;
      if (in_valid_i && !in_stall_o) begin
        predict_texels(in_item_i);
        blocks_per_fmt[cur_fmt]++;
      end
      if (out_valid_o && !out_stall_i) check_texel(out_item_o);
    end
  end

  // ---- stimulus ----

  function automatic logic [11:0] make_swizzle(logic [2:0] r, logic [2:0] g,
                                               logic [2:0] b, logic [2:0] a);
    return {a, b, g, r};
  endfunction

  function automatic in_item_t random_block();
    in_item_t blk;
    blk.block_low  = {$urandom, $urandom};
    blk.block_high = {$urandom, $urandom};
    if ($urandom_range(7) == 0) blk.block_low[31:16]  = blk.block_low[15:0];
    if ($urandom_range(7) == 0) blk.block_high[31:16] = blk.block_high[15:0];
    if ($urandom_range(7) == 0) blk.block_low[15:8]   = blk.block_low[7:0];
    if ($urandom_range(7) == 0) blk.block_high[15:8]  = blk.block_high[7:0];
    return blk;
  endfunction

  task automatic push_block(logic [63:0] lo, logic [63:0] hi);
    pending_blocks.insert(pending_blocks.size(), '{block_low: lo, block_high: hi});
  endtask

  task automatic push_random(int n);
    repeat (n) pending_blocks.insert(pending_blocks.size(), random_block());
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [11:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_BLOCK_FORMAT) cur_fmt = block_fmt_e'(data[1:0]);
    else cur_swizzle = data;
    config_writes++;
  endtask

  task automatic set_config(block_fmt_e fmt, logic [11:0] swz);
    write_reg(CFG_BLOCK_FORMAT, 12'(fmt));
    write_reg(CFG_CHANNEL_SWIZZLE, swz);
  endtask

  task automatic wait_drained();
    while (pending_blocks.size() != 0 || in_valid_i || expected_texels.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // sender mostly busy, receiver mostly stalled
    idle_pct  = 15;
    stall_pct = 77;

    // bc1 at reset settings: punch-through, four-colour and equal endpoints
    push_block('0, '0);
    push_block('1, '1);
    push_block({ALL_COLOR_IDX, 16'h0000, 16'hFFFF}, {$urandom, $urandom});
    push_block({ALL_COLOR_IDX, 16'hFFFF, 16'h0000}, {$urandom, $urandom});
    push_block({32'h1B1B_1B1B, 16'h07E0, 16'hF81F}, '0);
    push_block({ALL_COLOR_IDX, 16'h8410, 16'h8410}, '1);
    push_random(16);
    wait_drained();

    // bc2 with a long receiver hold-off while blocks keep coming
    set_config(FMT_BC2, SWIZZLE_RESET);
    push_block(64'hFEDC_BA98_7654_3210, {ALL_COLOR_IDX, 16'h0000, 16'hFFFF});
    push_block('0, {ALL_COLOR_IDX, 16'hFFFF, 16'h001F});
    push_block('1, '1);
    push_random(20);
    hold_req++;
    wait_drained();

    // sender mostly idle, receiver mostly ready
    idle_pct  = 77;
    stall_pct = 15;

    // bc3 with both alpha modes; folded selectors on green and blue
    set_config(FMT_BC3, make_swizzle(SEL_A, SEL_ZERO_ALT, SEL_FULL_ALT, SEL_R));
    push_block({ALL_ALPHA_IDX, 8'h00, 8'hFF}, {$urandom, $urandom});
    push_block({ALL_ALPHA_IDX, 8'hFF, 8'h00}, {$urandom, $urandom});
    push_block({ALL_ALPHA_IDX, 8'h80, 8'h80}, {$urandom, $urandom});
    push_block({ALL_ALPHA_IDX, 8'hF0, 8'h10}, {$urandom, $urandom});
    push_random(20);
    wait_drained();

    set_config(FMT_BC5, make_swizzle(SEL_G, SEL_R, SEL_B, SEL_A));
    push_block({ALL_ALPHA_IDX, 8'h00, 8'hFF}, {ALL_ALPHA_IDX, 8'hFF, 8'h00});
    push_block('0, '1);
    push_block('1, '0);
    push_random(20);
    wait_drained();

    // full rate on both sides
    idle_pct  = 0;
    stall_pct = 0;

    set_config(FMT_BC1, make_swizzle(SEL_R, SEL_R, SEL_R, SEL_R));
    push_random(10);
    wait_drained();

    set_config(FMT_BC3, make_swizzle(SEL_FULL_ALT, SEL_FULL_ALT, SEL_FULL_ALT, SEL_FULL_ALT));
    push_random(8);
    wait_drained();

    repeat (3) begin
      set_config(block_fmt_e'($urandom_range(3)), 12'($urandom_range(4095)));
      push_random(7);
      wait_drained();
    end

    $display("run covered %0d blocks (bc1 %0d, bc2 %0d, bc3 %0d, bc5 %0d), %0d texels",
             blocks_per_fmt[0] + blocks_per_fmt[1] + blocks_per_fmt[2] + blocks_per_fmt[3],
             blocks_per_fmt[0], blocks_per_fmt[1], blocks_per_fmt[2], blocks_per_fmt[3],
             texels_checked);
    $display("%0d register writes across formats and swizzles, %0d errors",
             config_writes, error_count);
    if (error_count == 0) begin
      $display("bc_texture_block_decoder_unit: match");
    end else begin
      $display("bc_texture_block_decoder_unit: mismatch");
    end
    $finish;
  end

endmodule
